[rtl/tii_pkg.sv]
// Package for the FIG 0/22 transmitter-identification parser.
// Types, constants and helpers shared by the front, queue and back ends.
package tii_pkg;

  localparam int unsigned TableEntries = 1024;
  localparam int unsigned KeyW = 10;
  localparam int unsigned AddrW = $clog2(TableEntries);
  localparam int unsigned QDepth = 2;

  localparam logic [2:0] KIND_IDENT = 3'd0;
  localparam logic [2:0] KIND_MAIN  = 3'd1;
  localparam logic [2:0] KIND_COUNT = 3'd2;
  localparam logic [2:0] KIND_SUB   = 3'd3;
  localparam logic [2:0] KIND_TRUNC = 3'd4;

  localparam logic [6:0] MainIdMax   = 7'd69;
  localparam logic [6:0] MainIdMaxM3 = 7'd5;
  localparam logic [4:0] SubIdMax    = 5'd23;

  localparam logic [2:0] MODE_1 = 3'd1;
  localparam logic [2:0] MODE_2 = 3'd2;
  localparam logic [2:0] MODE_3 = 3'd3;
  localparam logic [2:0] MODE_4 = 3'd4;

  // operation handed from front to back
  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_STORE = 2'd1,
    OP_SUB   = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [KeyW-1:0] key;
    logic signed [20:0] lat;
    logic signed [20:0] lon;
    logic [4:0]  small_value;
    logic [9:0]  delay_us;
    logic        main_known;
    logic        cycle_complete;
    logic        bad_value;
    logic        last_of_run;
  } res_t;

  typedef struct packed {
    op_e          op;
    logic [KeyW-1:0] key;
    logic [39:0]  pos;      // store: lat/lon raw; sub: 16-bit offsets in [31:0]
    res_t         r0;
    logic         r0_v;
    res_t         r1;
    logic         r1_v;
  } cmd_t;

endpackage

[rtl/tii_if.sv]
// Valid/ready channel interfaces for the parser.
// Depends on nothing.
interface tii_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;
  logic       other_ensemble;
  logic       pd_flag;
  modport source (output valid, func, data_byte, first_byte, last_byte,
                  other_ensemble, pd_flag, input ready);
  modport sink (input valid, func, data_byte, first_byte, last_byte,
                other_ensemble, pd_flag, output ready);
endinterface

interface tii_out_if;
  logic              valid;
  logic              ready;
  logic [2:0]        kind;
  logic [6:0]        main_id;
  logic [9:0]        db_key;
  logic signed [20:0] latitude;
  logic signed [20:0] longitude;
  logic [4:0]        small_value;
  logic [9:0]        delay_us;
  logic              main_known;
  logic              cycle_complete;
  logic              bad_value;
  logic              last_of_run;
  modport source (output valid, kind, main_id, db_key, latitude, longitude,
                  small_value, delay_us, main_known, cycle_complete, bad_value,
                  last_of_run, input ready);
  modport sink (input valid, kind, main_id, db_key, latitude, longitude,
                small_value, delay_us, main_known, cycle_complete, bad_value,
                last_of_run, output ready);
endinterface

[rtl/tii_database_parser.sv]
// Top level of the FIG 0/22 transmitter-identification parser.
// Depends on tii_pkg, tii_if, tii_front, tii_queue, tii_back.
//
//   channel   dir  handshake     payload
//   in_if     in   valid/ready   func, data_byte, first/last_byte, oe, pd
//   out_if    out  valid/ready   kind, ids, position, flags, last_of_run
//   cfg       in   cfg_we_i      transmission_mode
//
// One byte is taken per cycle while the command queue has room. Its first
// result is offered after the queue, the table read and the add into the output buffer.
// A byte causing two results holds the back end while both are offered.
// Reset and each clear request start a sweep over all TableEntries (1024)
// entries that zeroes the table valid bits; the back end takes no command meanwhile.
// Output stalls back up through a two-entry command queue to in_if.ready.
module tii_database_parser import tii_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_wdata_i,
  tii_in_if.sink     in_if,
  tii_out_if.source  out_if
);

  logic [2:0] mode_q;
  cmd_t fq_cmd, bq_cmd;
  logic fq_v, fq_r, bq_v, bq_r;
  res_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_1;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  tii_front u_front (
    .clk_i, .rst_ni, .mode_i(mode_q),
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .func_i(in_if.func), .data_byte_i(in_if.data_byte),
    .first_byte_i(in_if.first_byte), .last_byte_i(in_if.last_byte),
    .oe_i(in_if.other_ensemble), .pd_i(in_if.pd_flag),
    .cmd_valid_o(fq_v), .cmd_ready_i(fq_r), .cmd_o(fq_cmd)
  );

  tii_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(fq_v), .wr_ready_o(fq_r), .wr_data_i(fq_cmd),
    .rd_valid_o(bq_v), .rd_ready_i(bq_r), .rd_data_o(bq_cmd)
  );

  tii_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(bq_v), .cmd_ready_o(bq_r), .cmd_i(bq_cmd),
    .res_valid_o(out_if.valid), .res_ready_i(out_if.ready), .res_o(res)
  );

  assign out_if.kind           = res.kind;
  assign out_if.main_id        = res.key[6:0];
  assign out_if.db_key         = res.key;
  assign out_if.latitude       = res.lat;
  assign out_if.longitude      = res.lon;
  assign out_if.small_value    = res.small_value;
  assign out_if.delay_us       = res.delay_us;
  assign out_if.main_known     = res.main_known;
  assign out_if.cycle_complete = res.cycle_complete;
  assign out_if.bad_value      = res.bad_value;
  assign out_if.last_of_run    = res.last_of_run;

  a_known_only_sub: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.main_known |-> out_if.kind == KIND_SUB)
    else $error("main_known outside sub result");

  a_cyc_only_ident: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.cycle_complete |-> out_if.kind == KIND_IDENT)
    else $error("cycle_complete outside identifier result");

  a_queue_bp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fq_v && !fq_r |-> !in_if.ready)
    else $error("input accepted while queue full");

endmodule

[rtl/tii_front.sv]
// Front end: byte-level record parser, seen-identifier set and mode check.
// Depends on tii_pkg.
module tii_front import tii_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [2:0] mode_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       func_i,
  input  logic [7:0] data_byte_i,
  input  logic       first_byte_i,
  input  logic       last_byte_i,
  input  logic       oe_i,
  input  logic       pd_i,
  output logic       cmd_valid_o,
  input  logic       cmd_ready_i,
  output cmd_t       cmd_o
);

  typedef enum logic [1:0] {
    PH_ID    = 2'd0,
    PH_MAIN  = 2'd1,
    PH_COUNT = 2'd2,
    PH_SUB   = 2'd3
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [2:0]      idx_q, idx_d;
  logic [39:0]     buf_q, buf_d;
  logic [2:0]      left_q, left_d;
  logic [KeyW-1:0] key_q, key_d;
  logic [255:0]    seen_q, seen_d;

  logic   fire;
  cmd_t   c;
  res_t   r0, r1;
  logic   r0v, r1v;
  logic [6:0] mid;
  logic [7:0] ident;
  logic   bad;
  logic [19:0] latr, lonr;
  logic [4:0]  sid;

  assign in_ready_o  = cmd_ready_i;
  assign fire        = in_valid_i && in_ready_o;
  assign mid         = data_byte_i[6:0];
  assign ident       = data_byte_i;
  assign latr        = {buf_q[31:16], data_byte_i[7:4]};
  assign lonr        = {buf_q[15:0], data_byte_i[3:0]};
  assign sid         = buf_q[39:35];

  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    buf_d   = buf_q;
    left_d  = left_q;
    key_d   = key_q;
    seen_d  = seen_q;
    r0  = '0;
    r1  = '0;
    r0v = 1'b0;
    r1v = 1'b0;
    bad = 1'b0;
    c   = '0;
    c.op = OP_NONE;
    if (func_i) begin
      c.op = OP_CLEAR;
    end else if (first_byte_i) begin
      phase_d = PH_ID;
      idx_d   = '0;
      buf_d   = '0;
      left_d  = '0;
    end else begin
      unique case (phase_q)
        PH_ID: begin
          key_d = {oe_i, pd_i, mid};
          if (seen_q[ident]) begin
            seen_d = '0;
          end else begin
            seen_d[ident] = 1'b1;
          end
          if ((mode_i == MODE_1 || mode_i == MODE_2 || mode_i == MODE_4) &&
              mid > MainIdMax) begin
            bad = 1'b1;
          end else if (mode_i == MODE_3 && mid > MainIdMaxM3) begin
            bad = 1'b1;
          end
          r0v = 1'b1;
          r0.kind = KIND_IDENT;
          r0.key = key_d;
          r0.small_value = {4'd0, data_byte_i[7]};
          r0.cycle_complete = seen_q[ident];
          r0.bad_value = bad;
          phase_d = data_byte_i[7] ? PH_COUNT : PH_MAIN;
          idx_d = '0;
          buf_d = '0;
          if (last_byte_i) begin
            r1v = 1'b1;
            r1.kind = KIND_TRUNC;
            r1.key = key_d;
          end
        end
        PH_MAIN: begin
          if (idx_q < 3'd4) begin
            buf_d = {buf_q[31:0], data_byte_i};
            idx_d = idx_q + 3'd1;
            if (last_byte_i) begin
              r0v = 1'b1;
              r0.kind = KIND_TRUNC;
              r0.key = key_q;
            end
          end else begin
            c.op  = (key_q < KeyW'(TableEntries - 1) || TableEntries == 1024 ||
                     key_q == KeyW'(TableEntries - 1)) ? OP_STORE : OP_NONE;
            c.pos = {latr, lonr};
            r0v = 1'b1;
            r0.kind = KIND_MAIN;
            r0.key = key_q;
            r0.lat = {latr[19], latr};
            r0.lon = {lonr[19], lonr};
            phase_d = PH_ID;
            idx_d = '0;
            buf_d = '0;
          end
        end
        PH_COUNT: begin
          r0v = 1'b1;
          r0.kind = KIND_COUNT;
          r0.key = key_q;
          r0.small_value = {2'd0, data_byte_i[2:0]};
          r0.bad_value = |data_byte_i[7:3];
          idx_d = '0;
          buf_d = '0;
          if (data_byte_i[2:0] != 3'd0) begin
            phase_d = PH_SUB;
            left_d = data_byte_i[2:0];
          end else begin
            phase_d = PH_ID;
          end
        end
        PH_SUB: begin
          if (idx_q < 3'd5) begin
            buf_d = {buf_q[31:0], data_byte_i};
            idx_d = idx_q + 3'd1;
          end else begin
            c.op  = OP_SUB;
            c.pos = {8'd0, buf_q[23:8], buf_q[7:0], data_byte_i};
            r0v = 1'b1;
            r0.kind = KIND_SUB;
            r0.key = key_q;
            r0.small_value = sid;
            r0.delay_us = {buf_q[33:32], buf_q[31:24]};
            r0.bad_value = (sid == 5'd0) || (sid > SubIdMax);
            idx_d = '0;
            buf_d = '0;
            left_d = left_q - 3'd1;
            if (left_d == 3'd0) begin
              phase_d = PH_ID;
            end
          end
        end
        default: phase_d = PH_ID;
      endcase
      if (last_byte_i) begin
        phase_d = PH_ID;
        idx_d   = '0;
        buf_d   = '0;
        left_d  = '0;
      end
    end
    if (r1v) begin
      r1.last_of_run = 1'b1;
    end else if (r0v) begin
      r0.last_of_run = 1'b1;
    end
    c.key  = key_q;
    c.r0   = r0;
    c.r0_v = r0v;
    c.r1   = r1;
    c.r1_v = r1v;
  end

  assign cmd_o       = c;
  assign cmd_valid_o = fire && (c.op != OP_NONE || r0v);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_ID;
      idx_q   <= '0;
      buf_q   <= '0;
      left_q  <= '0;
      key_q   <= '0;
      seen_q  <= '0;
    end else if (fire) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      buf_q   <= buf_d;
      left_q  <= left_d;
      key_q   <= key_d;
      seen_q  <= seen_d;
    end
  end

endmodule

[rtl/tii_queue.sv]
// Two-entry command queue between front and back ends.
// Depends on tii_pkg.
module tii_queue import tii_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  cmd_t wr_data_i,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output cmd_t rd_data_o
);

  localparam int unsigned PtrW = $clog2(QDepth);

  cmd_t          mem_q [QDepth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [PtrW:0]   cnt_q;
  logic            wr, rd;

  assign wr_ready_o = cnt_q != (PtrW+1)'(QDepth);
  assign rd_valid_o = cnt_q != '0;
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wp_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + 1'b1;
      if (rd) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(wr) - (PtrW+1)'(rd);
    end
  end

endmodule

[rtl/tii_back.sv]
// Back end: position table with per-entry valid bit, sub position add, result sequencer.
// Depends on tii_pkg.
module tii_back import tii_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  output logic cmd_ready_o,
  input  cmd_t cmd_i,
  output logic res_valid_o,
  input  logic res_ready_i,
  output res_t res_o
);

  // stage 1: table read; stage 2: add and result buffer (two slots)
  // table entry: {valid, lat raw, lon raw}; valid bits zeroed by a sweep
  logic [40:0]       table_q [TableEntries];
  logic              sweep_q;
  logic [AddrW-1:0]  sw_addr_q;

  logic  s1_v_q;
  cmd_t  s1_q;
  logic [40:0] rd_q;
  logic  inr_q;
  logic  known;

  res_t  ob_q [2];
  logic [1:0] ob_v_q;
  logic  ob_h_q;

  logic  s1_go, take, s1_free, out_pop;
  logic [AddrW-1:0] addr;
  logic  in_range;
  res_t  r0;
  logic signed [20:0] blat, blon;

  assign addr     = cmd_i.key[AddrW-1:0];
  assign in_range = {1'b0, cmd_i.key} < (KeyW+1)'(TableEntries);
  assign out_pop  = res_valid_o && res_ready_i;
  // stage 1 can move when output buffer is empty or drains its last result
  assign s1_free  = (ob_v_q == 2'b00) ||
                    (out_pop && ($countones(ob_v_q) == 1));
  assign s1_go    = s1_v_q && s1_free;
  assign cmd_ready_o = !sweep_q && (!s1_v_q || s1_go);
  assign take     = cmd_valid_i && cmd_ready_o;

  always_ff @(posedge clk_i) begin
    if (sweep_q) begin
      table_q[sw_addr_q] <= '0;
    end else if (take && cmd_i.op == OP_STORE && in_range) begin
      table_q[addr] <= {1'b1, cmd_i.pos};
    end
    if (take) begin
      rd_q <= table_q[addr];
      s1_q <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q   <= 1'b1;
      sw_addr_q <= '0;
      s1_v_q    <= 1'b0;
      inr_q     <= 1'b0;
    end else begin
      if (sweep_q) begin
        sw_addr_q <= sw_addr_q + 1'b1;
        if (sw_addr_q == AddrW'(TableEntries - 1)) begin
          sweep_q <= 1'b0;
        end
      end else if (take && cmd_i.op == OP_CLEAR) begin
        sweep_q   <= 1'b1;
        sw_addr_q <= '0;
      end
      if (take) begin
        inr_q  <= in_range;
        s1_v_q <= 1'b1;
      end else if (s1_go) begin
        s1_v_q <= 1'b0;
      end
    end
  end

  assign known = inr_q && rd_q[40];
  assign blat = known ? {rd_q[39], rd_q[39:20]} : '0;
  assign blon = known ? {rd_q[19], rd_q[19:0]} : '0;

  always_comb begin
    r0 = s1_q.r0;
    if (s1_q.op == OP_SUB) begin
      r0.lat = blat + {{5{s1_q.pos[31]}}, s1_q.pos[31:16]};
      r0.lon = blon + {{5{s1_q.pos[15]}}, s1_q.pos[15:0]};
      r0.main_known = known;
    end
  end

  assign res_valid_o = ob_v_q[ob_h_q];
  assign res_o       = ob_q[ob_h_q];

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      ob_q[0] <= r0;
      ob_q[1] <= s1_q.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_v_q <= '0;
      ob_h_q <= 1'b0;
    end else if (s1_go) begin
      ob_v_q <= {s1_q.r1_v, s1_q.r0_v};
      ob_h_q <= !s1_q.r0_v;
    end else if (out_pop) begin
      ob_v_q[ob_h_q] <= 1'b0;
      ob_h_q <= 1'b1;
    end
  end

endmodule
